>>> rtl/puct_child_select_assert.svh
// assertion macros used by the child selection back end
`ifndef PUCT_CHILD_SELECT_ASSERT_SVH
`define PUCT_CHILD_SELECT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcs check failed");

// next-cycle implication, checked out of reset
`define PCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcs check failed");

`endif

>>> rtl/pcs_pkg.sv
// types and constants of the puct child selection block
package pcs_pkg;

  // widest position / count carried in a queued word
  localparam int unsigned POS_W   = 9;
  localparam int unsigned SCORE_W = 30;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 30'sd268435455;

  // classified child word between front and back
  typedef struct packed {
    logic signed [15:0] value;
    logic [15:0]        prior;
    logic [15:0]        visits;
    logic [15:0]        parent;
    logic               last;
    logic               first;
    logic               over;
    logic               ovf;
    logic [POS_W-1:0]   idx;
    logic [POS_W-1:0]   cnt;
  } item_t;

  // queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } back_state_e;

endpackage

>>> rtl/pcs_front.sv
// front end: takes child words, tracks group position and classifies them
module pcs_front #(
  parameter int unsigned MAX_CHILDREN = 64,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [63:0]    in_data_i,
  input  logic           in_last_i,
  input  logic           q_full_i,
  output logic           in_ready_o,
  output logic           push_o,
  output pcs_pkg::item_t item_o
);

  localparam int unsigned PW = $clog2(MAX_CHILDREN + 1);
  localparam logic [15:0] VMASK =
    (COUNT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COUNT_BITS) - 32'd1);

  logic [PW-1:0] pos_q, pos_d;
  logic          ovf_q, ovf_d;
  logic          over;
  logic [PW-1:0] cnt;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify against the running position
  assign over = (pos_q >= PW'(MAX_CHILDREN));
  assign cnt  = over ? pos_q : pos_q + PW'(1);

  always_comb begin
    item_o        = '0;
    item_o.value  = in_data_i[15:0];
    item_o.prior  = in_data_i[31:16];
    item_o.visits = in_data_i[47:32] & VMASK;
    item_o.parent = in_data_i[63:48] & VMASK;
    item_o.last   = in_last_i;
    item_o.first  = (pos_q == '0);
    item_o.over   = over;
    item_o.ovf    = ovf_q || over;
    item_o.idx    = pcs_pkg::POS_W'(pos_q);
    item_o.cnt    = pcs_pkg::POS_W'(cnt);
  end

  // next group position
  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    if (push_o) begin
      if (in_last_i) begin
        pos_d = '0;
        ovf_d = 1'b0;
      end else begin
        pos_d = cnt;
        ovf_d = ovf_q || over;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

>>> rtl/pcs_queue.sv
// two-word queue between front and back
module pcs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pcs_pkg::item_t   item_i,
  input  logic             pop_i,
  output pcs_pkg::item_t   item_o,
  output pcs_pkg::q_stat_t stat_o
);

  pcs_pkg::item_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;

  assign item_o       = mem_q[rp_q];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> rtl/pcs_back.sv
// back end: square root, scoring, running maximum and result register
module pcs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      c_puct_i,
  input  pcs_pkg::item_t   item_i,
  input  pcs_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [47:0]      out_data_o,
  output logic             out_ovf_o
);

  localparam int unsigned SW = pcs_pkg::SCORE_W;

  pcs_pkg::back_state_e state_q, state_d;
  pcs_pkg::item_t       cur_q;

  logic [31:0]          sx_q;
  logic [16:0]          srem_q;
  logic [15:0]          root_q;
  logic [4:0]           cyc_q;
  logic [31:0]          p1_q;
  logic [27:0]          num_q;
  logic [16:0]          div_q;
  logic [16:0]          drem_q;
  logic signed [SW-1:0] best_q;
  logic [5:0]           bidx_q;
  logic                 out_valid_q;
  logic [47:0]          out_data_q;
  logic                 out_ovf_q;

  logic [17:0]          s_rem;
  logic [17:0]          s_try;
  logic [17:0]          d_rem;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] score;
  logic                 load_out;
  logic [47:0]          p2;

  // square root step: two bits of radicand per cycle
  assign s_rem = {srem_q[15:0], sx_q[31:30]};
  assign s_try = {root_q, 2'b01};
  // divide step: one quotient bit per cycle
  assign d_rem = {drem_q, num_q[27]};
  assign p2    = p1_q * root_q;

  // score of the current child with saturation
  assign sum   = -(SW'(cur_q.value) <<< 1) + SW'(num_q);
  assign score = (sum > pcs_pkg::SCORE_MAX) ? pcs_pkg::SCORE_MAX : sum;

  assign load_out = (state_q == pcs_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      pcs_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (!item_i.over) begin
            state_d = item_i.first ? pcs_pkg::ST_SQRT : pcs_pkg::ST_MUL1;
          end else if (item_i.last) begin
            state_d = pcs_pkg::ST_EMIT;
          end
        end
      end
      pcs_pkg::ST_SQRT: if (cyc_q == 5'd15) state_d = pcs_pkg::ST_MUL1;
      pcs_pkg::ST_MUL1: state_d = pcs_pkg::ST_MUL2;
      pcs_pkg::ST_MUL2: state_d = pcs_pkg::ST_DIV;
      pcs_pkg::ST_DIV:  if (cyc_q == 5'd27) state_d = pcs_pkg::ST_UPD;
      pcs_pkg::ST_UPD:  state_d = cur_q.last ? pcs_pkg::ST_EMIT : pcs_pkg::ST_IDLE;
      pcs_pkg::ST_EMIT: if (load_out) state_d = pcs_pkg::ST_IDLE;
      default:          state_d = pcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pcs_pkg::ST_IDLE: begin
        cur_q  <= item_i;
        sx_q   <= {item_i.parent, 16'd0};
        srem_q <= '0;
        cyc_q  <= '0;
        // only a word actually popped may restart the root
        if (!q_stat_i.empty && item_i.first) root_q <= '0;
      end
      pcs_pkg::ST_SQRT: begin
        sx_q  <= {sx_q[29:0], 2'b00};
        cyc_q <= cyc_q + 5'd1;
        if (s_rem >= s_try) begin
          srem_q <= 17'(s_rem - s_try);
          root_q <= {root_q[14:0], 1'b1};
        end else begin
          srem_q <= s_rem[16:0];
          root_q <= {root_q[14:0], 1'b0};
        end
      end
      pcs_pkg::ST_MUL1: begin
        p1_q  <= c_puct_i * cur_q.prior;
        div_q <= 17'(cur_q.visits) + 17'd1;
      end
      pcs_pkg::ST_MUL2: begin
        num_q  <= p2[47:20];
        drem_q <= '0;
        cyc_q  <= '0;
      end
      pcs_pkg::ST_DIV: begin
        cyc_q <= cyc_q + 5'd1;
        if (d_rem >= 18'(div_q)) begin
          drem_q <= 17'(d_rem - 18'(div_q));
          num_q  <= {num_q[26:0], 1'b1};
        end else begin
          drem_q <= d_rem[16:0];
          num_q  <= {num_q[26:0], 1'b0};
        end
      end
      pcs_pkg::ST_UPD: begin
        if (cur_q.first || (score > best_q)) begin
          best_q <= score;
          bidx_q <= cur_q.idx[5:0];
        end
      end
      pcs_pkg::ST_EMIT: begin
        if (load_out) begin
          out_data_q <= {6'd0, cur_q.cnt[6:0], best_q[28:0], bidx_q};
          out_ovf_q  <= cur_q.ovf;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_ovf_o   = out_ovf_q;

  `include "puct_child_select_assert.svh"

  `PCS_ASSERT_NOW(a_div_nonzero, state_q == pcs_pkg::ST_DIV, div_q != 17'd0)
  `PCS_ASSERT_NOW(a_sqrt_first, state_q == pcs_pkg::ST_SQRT, cur_q.first)
  `PCS_ASSERT_NEXT(a_load_valid, load_out, out_valid_q)
  `PCS_ASSERT_NOW(a_pop_idle, pop_o, state_q == pcs_pkg::ST_IDLE)

endmodule

>>> rtl/puct_child_select.sv
// top level of the puct child selection block
// Child selection by the PUCT rule. Each input word is one child; tlast marks the
// last child of a group, and the group's first word supplies the parent visit count.
// One result word (best index, score, child count, overflow in tuser) follows each
// group. A front end classifies words into a two-word queue; the back end scores them
// one at a time: two multiply steps, a bit-serial divide by visits plus one and an
// update per child, plus a square root on the first child of each group. Children
// past MAX_CHILDREN are popped without scoring and only set the overflow flag.
module puct_child_select #(
  parameter int unsigned MAX_CHILDREN = 64,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // c_puct, Q4.12
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // child_value, child_prior, child_visits, parent_visits
  input  logic        s_axis_tlast_i,  // last_child
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // best_index, best_score, child_count, zero pad
  output logic        m_axis_tuser_o   // overflow
);

  logic [15:0]      c_puct_q;
  logic             push;
  logic             pop;
  pcs_pkg::item_t   f_item;
  pcs_pkg::item_t   q_item;
  pcs_pkg::q_stat_t q_stat;

  // exploration weight register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_puct_q <= 16'd4096;
    end else if (cfg_we_i) begin
      c_puct_q <= cfg_wdata_i;
    end
  end

  pcs_front #(
    .MAX_CHILDREN (MAX_CHILDREN),
    .COUNT_BITS   (COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_stat.full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .item_o     (f_item)
  );

  pcs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  pcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .c_puct_i    (c_puct_q),
    .item_i      (q_item),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_ovf_o   (m_axis_tuser_o)
  );

endmodule
